/* sv/aesenc_pkg.sv */
// shared types, constants and round functions for the aes-256 encrypt unit
package aesenc_pkg;

  localparam int unsigned BlockW = 128;
  localparam int unsigned HalfW = 64;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned NumRounds = 14;
  localparam int unsigned NumSched = 60;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_KEY_WORD_0 = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY_WORD_1 = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_KEY_WORD_2 = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_KEY_WORD_3 = 8'd3;

  localparam logic [7:0] GF_POLY = 8'h1b;

  typedef enum logic [1:0] {
    KS_IDLE,
    KS_LOAD,
    KS_EXPAND
  } ks_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic busy;
  } ks_ctrl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // round constant for schedule word group 1..7
  function automatic logic [7:0] rcon(input logic [2:0] grp);
    logic [7:0] r;
    unique case (grp)
      3'd1: r = 8'h01;
      3'd2: r = 8'h02;
      3'd3: r = 8'h04;
      3'd4: r = 8'h08;
      3'd5: r = 8'h10;
      3'd6: r = 8'h20;
      3'd7: r = 8'h40;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] mix_column(input logic [31:0] col);
    logic [7:0] a, b, c, d;
    a = col[31:24];
    b = col[23:16];
    c = col[15:8];
    d = col[7:0];
    return {xtime(a) ^ xtime(b) ^ b ^ c ^ d,
            a ^ xtime(b) ^ xtime(c) ^ c ^ d,
            a ^ b ^ xtime(c) ^ xtime(d) ^ d,
            xtime(a) ^ a ^ b ^ c ^ xtime(d)};
  endfunction

endpackage

/* sv/aesenc_if.sv */
// handshake channels of the aes-256 encrypt unit
interface aesenc_plain_if;
  logic        valid;
  logic        ready;
  logic [63:0] plain_high;
  logic [63:0] plain_low;
  modport source (output valid, plain_high, plain_low, input ready);
  modport sink (input valid, plain_high, plain_low, output ready);
endinterface

interface aesenc_cipher_if;
  logic        valid;
  logic        ready;
  logic [63:0] cipher_high;
  logic [63:0] cipher_low;
  modport source (output valid, cipher_high, cipher_low, input ready);
  modport sink (input valid, cipher_high, cipher_low, output ready);
endinterface

interface aesenc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/aesenc_round.sv */
// one aes cipher round: subbytes, shiftrows, optional mixcolumns, addroundkey
module aesenc_round
  import aesenc_pkg::*;
#(
  parameter bit FINAL = 1'b0
) (
  input  logic [BlockW-1:0] state_in,
  input  logic [BlockW-1:0] round_key,
  output logic [BlockW-1:0] state_out
);

  logic [BlockW-1:0] shifted;
  logic [BlockW-1:0] mixed;

  // byte k sits at bits 127-8k; output byte 4c+r comes from byte 4((c+r)%4)+r
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        shifted[BlockW-1-8*(4*c+r) -: 8] =
          SBOX[state_in[BlockW-1-8*(4*((c+r)%4)+r) -: 8]];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      if (FINAL) begin
        mixed[BlockW-1-32*c -: 32] = shifted[BlockW-1-32*c -: 32];
      end else begin
        mixed[BlockW-1-32*c -: 32] = mix_column(shifted[BlockW-1-32*c -: 32]);
      end
    end
  end

  assign state_out = mixed ^ round_key;

endmodule

/* sv/aes256_block_encrypt_unit.sv */
// aes-256 block encryption: key schedule expander and 15-stage round pipeline
// items pass the initial key add stage, then one register stage per cipher round
// throughput: one item per cycle while no stall or key expansion holds the input
// key schedule: one load and 52 word steps after reset and after each key register
// write; no plaintext item is accepted during that time
// reset: synchronous, clears key registers, pipeline valid bits, expands the zero key
module aes256_block_encrypt_unit
  import aesenc_pkg::*;
(
  input logic             clk,
  input logic             rst,
  aesenc_plain_if.sink    plain,
  aesenc_cipher_if.source cipher,
  aesenc_cfg_if.sink      cfg
);

  localparam int unsigned NumStages = NumRounds + 1;

  // configuration registers
  logic [HalfW-1:0] key_regs [4];
  logic             cfg_hit;

  assign cfg.ready = 1'b1;
  assign cfg_hit = cfg.valid && (cfg.index == REG_KEY_WORD_0 || cfg.index == REG_KEY_WORD_1 ||
                                 cfg.index == REG_KEY_WORD_2 || cfg.index == REG_KEY_WORD_3);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++) key_regs[k] <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_KEY_WORD_0: key_regs[0] <= cfg.data;
        REG_KEY_WORD_1: key_regs[1] <= cfg.data;
        REG_KEY_WORD_2: key_regs[2] <= cfg.data;
        REG_KEY_WORD_3: key_regs[3] <= cfg.data;
        default: ;
      endcase
    end
  end

  // key schedule sequencer
  ks_state_t ks_state, ks_state_next;
  ks_ctrl_t  ks_ctrl;
  logic [5:0] ks_idx;

  always_comb begin
    ks_state_next = ks_state;
    unique case (ks_state)
      KS_IDLE:   ks_state_next = KS_IDLE;
      KS_LOAD:   ks_state_next = KS_EXPAND;
      KS_EXPAND: if (ks_idx == 6'(NumSched - 1)) ks_state_next = KS_IDLE;
      default:   ks_state_next = KS_IDLE;
    endcase
    // a key write restarts expansion from the new registers
    if (cfg_hit) ks_state_next = KS_LOAD;
  end

  always_comb begin
    ks_ctrl = '0;
    unique case (ks_state)
      KS_IDLE: ;
      KS_LOAD: begin
        ks_ctrl.load = 1'b1;
        ks_ctrl.busy = 1'b1;
      end
      KS_EXPAND: begin
        ks_ctrl.step = 1'b1;
        ks_ctrl.busy = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ks_state <= KS_LOAD;
    end else begin
      ks_state <= ks_state_next;
    end
  end

  // sliding window of the last eight schedule words; win[0] is w[i-8], win[7] is w[i-1]
  logic [31:0] win [8];
  logic [31:0] ks_temp;
  logic [31:0] ks_word;
  logic [31:0] rk [NumSched];

  always_comb begin
    if (ks_idx[2:0] == 3'd0) begin
      ks_temp = sub_word({win[7][23:0], win[7][31:24]}) ^ {rcon(ks_idx[5:3]), 24'h0};
    end else if (ks_idx[2:0] == 3'd4) begin
      ks_temp = sub_word(win[7]);
    end else begin
      ks_temp = win[7];
    end
  end

  assign ks_word = win[0] ^ ks_temp;

  always_ff @(posedge clk) begin
    if (rst) begin
      ks_idx <= '0;
    end else if (ks_ctrl.load) begin
      ks_idx <= 6'd8;
    end else if (ks_ctrl.step) begin
      ks_idx <= ks_idx + 6'd1;
    end
  end

  // schedule words are payload: no reset, written by the sequencer only
  always_ff @(posedge clk) begin
    if (ks_ctrl.load) begin
      for (int j = 0; j < 8; j++) begin
        win[j] <= (j % 2 == 0) ? key_regs[j/2][63:32] : key_regs[j/2][31:0];
        rk[j]  <= (j % 2 == 0) ? key_regs[j/2][63:32] : key_regs[j/2][31:0];
      end
    end else if (ks_ctrl.step) begin
      for (int j = 0; j < 7; j++) win[j] <= win[j+1];
      win[7] <= ks_word;
      rk[ks_idx] <= ks_word;
    end
  end

  // round pipeline: stage 0 is the initial key add, stage r is cipher round r
  logic [BlockW-1:0] st [NumStages];
  logic [BlockW-1:0] round_out [NumStages];
  logic [BlockW-1:0] round_key [NumStages];
  logic [NumStages-1:0] vld;
  logic [NumStages-1:0] adv;
  logic plain_take;

  genvar g;
  for (g = 0; g < NumStages; g++) begin : g_key
    assign round_key[g] = {rk[4*g], rk[4*g+1], rk[4*g+2], rk[4*g+3]};
  end

  assign round_out[0] = {plain.plain_high, plain.plain_low} ^ round_key[0];

  for (g = 1; g < NumStages; g++) begin : g_round
    aesenc_round #(
      .FINAL(g == NumStages - 1)
    ) u_round (
      .state_in (st[g-1]),
      .round_key(round_key[g]),
      .state_out(round_out[g])
    );
  end

  // a stage moves when it is empty or its successor moves, so bubbles close up
  always_comb begin
    adv[NumStages-1] = !vld[NumStages-1] || cipher.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign plain.ready = adv[0] && !ks_ctrl.busy;
  assign plain_take  = plain.valid && plain.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= plain_take;
      for (int k = 1; k < NumStages; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) st[0] <= round_out[0];
    for (int k = 1; k < NumStages; k++) begin
      if (adv[k]) st[k] <= round_out[k];
    end
  end

  assign cipher.valid       = vld[NumStages-1];
  assign cipher.cipher_high = st[NumStages-1][BlockW-1:HalfW];
  assign cipher.cipher_low  = st[NumStages-1][HalfW-1:0];

  // no plaintext item enters while the schedule is being rebuilt
  assert property (@(posedge clk) disable iff (rst)
    plain_take |-> ks_state == KS_IDLE)
    else $error("item accepted during key expansion");

  // a key write always restarts expansion
  assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> ks_state == KS_LOAD)
    else $error("key write did not restart expansion");

  // expansion index stays within the generated schedule words
  assert property (@(posedge clk) disable iff (rst)
    ks_state == KS_EXPAND |-> (ks_idx >= 6'd8 && ks_idx <= 6'(NumSched - 1)))
    else $error("schedule index out of range");

  // a held result is not dropped by the pipeline
  assert property (@(posedge clk) disable iff (rst)
    vld[NumStages-1] && !cipher.ready |=> vld[NumStages-1])
    else $error("stalled result lost");

endmodule

/* tb/tb_aes256_block_encrypt_unit.sv */
// self-checking testbench for the aes-256 block encrypt unit
module tb_aes256_block_encrypt_unit;
  import aesenc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } block_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  aesenc_plain_if  plain ();
  aesenc_cipher_if cipher ();
  aesenc_cfg_if    cfg ();

  aes256_block_encrypt_unit u_top (
    .clk    (clk),
    .rst    (rst),
    .plain  (plain),
    .cipher (cipher),
    .cfg    (cfg)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: key registers and the expanded schedule
  logic [63:0] key_regs [4];
  logic [31:0] sched [NumSched];

  block_t pending_plain [$];
  block_t expected_cipher [$];

  int errors = 0;
  int checked = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;
  int hold_cycles = 0;
  int key_sets = 0;

  // gf(2^8) multiply by two
  function automatic logic [7:0] gf_dbl(input logic [7:0] v);
    return v[7] ? ({v[6:0], 1'b0} ^ 8'h1b) : {v[6:0], 1'b0};
  endfunction

  function automatic logic [31:0] sbox_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // rebuild the 60-word schedule from the key registers
  task automatic expand_key_schedule();
    logic [31:0] t;
    logic [7:0] rc;
    for (int i = 0; i < 8; i++) begin
      sched[i] = i[0] ? key_regs[i >> 1][31:0] : key_regs[i >> 1][63:32];
    end
    for (int i = 8; i < NumSched; i++) begin
      t = sched[i-1];
      if ((i % 8) == 0) begin
        rc = 8'h01 << ((i / 8) - 1);
        t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
      end else if ((i % 8) == 4) begin
        t = sbox_word(t);
      end
      sched[i] = sched[i-8] ^ t;
    end
  endtask

  // full 14-round encryption of one block, state held as 16 bytes
  function automatic block_t encrypt_block(input block_t pt);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a, b, c, d;
    block_t ct;
    for (int i = 0; i < 8; i++) begin
      s[i] = pt.hi[63-8*i -: 8];
      s[8+i] = pt.lo[63-8*i -: 8];
    end
    for (int rnd = 0; rnd <= NumRounds; rnd++) begin
      if (rnd > 0) begin
        // sub bytes and shift rows
        for (int col = 0; col < 4; col++)
          for (int row = 0; row < 4; row++)
            t[4*col+row] = SBOX[s[4*((col+row)%4)+row]];
        s = t;
        // mix columns except on the last round
        if (rnd < NumRounds) begin
          for (int col = 0; col < 4; col++) begin
            a = s[4*col]; b = s[4*col+1]; c = s[4*col+2]; d = s[4*col+3];
            s[4*col]   = gf_dbl(a) ^ gf_dbl(b) ^ b ^ c ^ d;
            s[4*col+1] = a ^ gf_dbl(b) ^ gf_dbl(c) ^ c ^ d;
            s[4*col+2] = a ^ b ^ gf_dbl(c) ^ gf_dbl(d) ^ d;
            s[4*col+3] = gf_dbl(a) ^ a ^ b ^ c ^ gf_dbl(d);
          end
        end
      end
      // add round key
      for (int col = 0; col < 4; col++)
        for (int k = 0; k < 4; k++)
          s[4*col+k] ^= sched[4*rnd+col][31-8*k -: 8];
    end
    for (int i = 0; i < 8; i++) begin
      ct.hi[63-8*i -: 8] = s[i];
      ct.lo[63-8*i -: 8] = s[8+i];
    end
    return ct;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  // plaintext driver: random gap before an item, some items sent back to back
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      plain.valid <= 1'b0;
      send_gap <= $urandom_range(0, 12);
    end else if (plain.valid && plain.ready) begin
      // item taken; next one after its own gap, or straight away
      void'(pending_plain.pop_front());
      if (pending_plain.size() > 0 && $urandom_range(0, 3) == 0) begin
        plain.valid <= 1'b1;
        plain.plain_high <= pending_plain[0].hi;
        plain.plain_low <= pending_plain[0].lo;
      end else begin
        plain.valid <= 1'b0;
        send_gap <= $urandom_range(0, 12);
      end
    end else if (!plain.valid && pending_plain.size() > 0) begin
      if (send_gap == 0) begin
        plain.valid <= 1'b1;
        plain.plain_high <= pending_plain[0].hi;
        plain.plain_low <= pending_plain[0].lo;
      end else begin
        send_gap <= send_gap - 1;
      end
    end
  end

  // predict at acceptance, so the schedule in use is the current one
  always @(posedge clk) begin
    if (!rst && plain.valid && plain.ready)
      expected_cipher.push_back(encrypt_block('{plain.plain_high, plain.plain_low}));
  end

  // ciphertext monitor with random back-pressure
  int recv_gap = 0;
  always @(posedge clk) begin
    block_t want;
    if (rst) begin
      cipher.ready <= 1'b0;
      recv_gap <= $urandom_range(0, 12);
    end else begin
      if (cipher.valid && cipher.ready) begin
        if (expected_cipher.size() == 0) begin
          report_mismatch("unexpected item", cipher.cipher_high, '0);
        end else begin
          want = expected_cipher.pop_front();
          if (cipher.cipher_high !== want.hi)
            report_mismatch("cipher_high", cipher.cipher_high, want.hi);
          if (cipher.cipher_low !== want.lo)
            report_mismatch("cipher_low", cipher.cipher_low, want.lo);
          checked++;
        end
        // burst mode sometimes, otherwise a fresh stall
        if (!hold_off && $urandom_range(0, 2) == 0) begin
          cipher.ready <= 1'b1;
        end else begin
          cipher.ready <= 1'b0;
          recv_gap <= $urandom_range(0, 12);
        end
      end else if (hold_off) begin
        cipher.ready <= 1'b0;
      end else if (!cipher.ready) begin
        if (recv_gap == 0) cipher.ready <= 1'b1;
        else recv_gap <= recv_gap - 1;
      end
    end
  end

  // long receiver hold-off, counted here, so the pipeline fills and stalls its input
  initial begin
    wait (key_sets == 2);
    hold_off = 1'b1;
    while (hold_cycles < 200) begin
      @(posedge clk);
      hold_cycles++;
    end
    hold_off = 1'b0;
  end

  // watchdog: cycles with no handshake on any channel
  always @(posedge clk) begin
    if (rst || (plain.valid && plain.ready) || (cipher.valid && cipher.ready) ||
        (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 2000) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("aes256_block_encrypt_unit regression: fail");
      $finish;
    end
  end

  // write one key register, waiting for the handshake; the channel then idles before return
  task automatic write_key_reg(input logic [7:0] idx, input logic [63:0] value);
    cfg.index <= idx;
    cfg.data <= value;
    cfg.valid <= 1'b1;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    case (idx)
      REG_KEY_WORD_0: key_regs[0] = value;
      REG_KEY_WORD_1: key_regs[1] = value;
      REG_KEY_WORD_2: key_regs[2] = value;
      REG_KEY_WORD_3: key_regs[3] = value;
      default: ;
    endcase
    expand_key_schedule();
    @(posedge clk);
  endtask

  task automatic load_key(input logic [63:0] k0, input logic [63:0] k1,
                          input logic [63:0] k2, input logic [63:0] k3);
    write_key_reg(REG_KEY_WORD_0, k0);
    write_key_reg(REG_KEY_WORD_1, k1);
    write_key_reg(REG_KEY_WORD_2, k2);
    write_key_reg(REG_KEY_WORD_3, k3);
  endtask

  // wait until every queued item is sent and every result has come back;
  // queues are sampled mid-cycle so a pop and its matching push are both seen
  task automatic drain();
    do @(negedge clk);
    while (pending_plain.size() > 0 || expected_cipher.size() > 0);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // mostly random blocks, with some all-zero / all-one halves and walking bits
  task automatic queue_random(input int n);
    block_t b;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      b.hi = rand64();
      b.lo = rand64();
      if (pick == 0) b.hi = '0;
      if (pick == 1) b.lo = '1;
      if (pick == 2) b = block_t'(128'h1 << $urandom_range(0, 127));
      pending_plain.push_back(b);
    end
  endtask

  initial begin
    plain.valid = 1'b0;
    plain.plain_high = '0;
    plain.plain_low = '0;
    cipher.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    for (int i = 0; i < 4; i++) key_regs[i] = '0;
    expand_key_schedule();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: reset key (all zero), then extremes of the plaintext
    pending_plain.push_back('{64'h0, 64'h0});
    pending_plain.push_back('{64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff});
    pending_plain.push_back('{64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001});
    pending_plain.push_back('{64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff});
    drain();

    // fips-197 appendix c.3 key, plus two out-of-range indexes that must be ignored
    load_key(64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f,
             64'h1011_1213_1415_1617, 64'h1819_1a1b_1c1d_1e1f);
    write_key_reg(8'hff, rand64());
    write_key_reg(8'd4, rand64());
    pending_plain.push_back('{64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff});
    pending_plain.push_back('{64'h0, 64'h0});
    pending_plain.push_back('{64'hffff_ffff_ffff_ffff, 64'h0});
    drain();

    // all-ones key
    load_key('1, '1, '1, '1);
    pending_plain.push_back('{64'h0, 64'hffff_ffff_ffff_ffff});
    pending_plain.push_back('{64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210});
    drain();
    key_sets = 1;

    // random phases: each with a newly loaded key (all zero in the fourth), one single-word rewrite in the second
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 3) load_key('0, '0, '0, '0);
      else load_key(rand64(), rand64(), rand64(), rand64());
      if (ph == 1) write_key_reg(REG_KEY_WORD_2, rand64());
      key_sets = key_sets + 1;
      queue_random(90);
      drain();
    end

    $display("covered %0d ciphertext blocks under %0d key settings,", checked, key_sets + 2);
    $display("including a %0d-cycle receiver hold-off", hold_cycles);
    if (errors == 0) begin
      $display("aes256_block_encrypt_unit regression: pass");
    end else begin
      $display("aes256_block_encrypt_unit regression: fail");
    end
    $finish;
  end

endmodule
